// ===== hdl/arp_pkg.sv =====
// Shared types and constants for the ARP request responder.
// No dependencies; imported by every module of the block.
package arp_pkg;

   localparam int HDR_LEN  = 42;
   localparam int HDR_BITS = HDR_LEN * 8;
   localparam int IDX_W    = 6;

   localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;
   localparam logic [15:0] ARP_OP_REPLY  = 16'h0002;
   localparam logic [7:0]  ARP_OP_REQ_HI = 8'h00;
   localparam logic [7:0]  ARP_OP_REQ_LO = 8'h01;

   localparam logic [47:0] MAC0_RESET = 48'h0200_0000_0001;
   localparam logic [31:0] GW0_RESET  = 32'hC0A8_0101;
   localparam logic [47:0] MAC1_RESET = 48'h0200_0000_0002;
   localparam logic [31:0] GW1_RESET  = 32'hC0A8_0201;

   typedef enum logic [1:0] {
      CSR_MAC_PORT0 = 2'd0,
      CSR_GW_PORT0  = 2'd1,
      CSR_MAC_PORT1 = 2'd2,
      CSR_GW_PORT1  = 2'd3
   } csr_index_type;

   // Load request from the header parser to the reply shifter
   typedef struct packed {
      logic                load_reply;
      logic                load_pass;
      logic [7:0]          data;
      logic                last;
      logic                port;
      logic [HDR_BITS-1:0] hdr;
   } load_req_type;

endpackage

// ===== hdl/arp_request_responder_core.sv =====
// The first reply byte is offered the cycle after byte 41 is accepted; the 42-byte
// reply then drains one byte per cycle from the reply shifter while rsp_stall is low.
// Input is taken one byte per cycle while the output does not stall, except that input
// is held off while a reply header drains; the next byte is taken as the last reply
// byte leaves. Pass-through bytes are registered in the reply shifter. Reset clears the
// byte counter, flags and output count and restores the MAC and gateway registers.
module arp_request_responder_core
   import arp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_frame_last,
   input  logic        req_port,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   output logic        rsp_reply_port,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [47:0] csr_wdata
);

   logic [47:0]  mac0_ff, mac1_ff;
   logic [31:0]  gw0_ff, gw1_ff;
   logic [47:0]  mac_sel;
   logic [31:0]  gw_sel;
   logic         can_load;
   logic         accept;
   load_req_type load;

   assign req_stall = !can_load;
   assign accept    = req_valid && can_load;
   assign mac_sel   = req_port ? mac1_ff : mac0_ff;
   assign gw_sel    = req_port ? gw1_ff : gw0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac0_ff <= MAC0_RESET;
         gw0_ff  <= GW0_RESET;
         mac1_ff <= MAC1_RESET;
         gw1_ff  <= GW1_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MAC_PORT0: mac0_ff <= csr_wdata;
            CSR_GW_PORT0:  gw0_ff  <= csr_wdata[31:0];
            CSR_MAC_PORT1: mac1_ff <= csr_wdata;
            CSR_GW_PORT1:  gw1_ff  <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   arp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .frame_last (req_frame_last),
      .port       (req_port),
      .mac        (mac_sel),
      .gw         (gw_sel),
      .load       (load)
   );

   arp_reply_shifter u_shifter (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_out_last   (rsp_out_last),
      .rsp_reply_port (rsp_reply_port)
   );

`ifndef ASSERT_OFF
   a_reply_offered: assert property (@(posedge clock) disable iff (reset)
      load.load_reply |=> rsp_valid && !rsp_out_last)
      else $error("reply header not offered after match");

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input held off with nothing to send");

   a_one_load: assert property (@(posedge clock) disable iff (reset)
      !(load.load_reply && load.load_pass))
      else $error("reply and pass-through loaded together");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");
`endif

endmodule

// ===== hdl/arp_parser.sv =====
// Header parser: shifts frame bytes into the ARP field registers and
// decides at byte 41 whether to answer. Depends on arp_pkg.
module arp_parser
   import arp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         data_byte,
   input  logic               frame_last,
   input  logic               port,
   input  logic [47:0]        mac,
   input  logic [31:0]        gw,
   output load_req_type       load
);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [47:0]      eth_src_ff, eth_src_in;
   logic [47:0]      fixed_ff, fixed_in;
   logic [47:0]      sender_hw_ff, sender_hw_in;
   logic [31:0]      snd_ip_ff, snd_ip_in;
   logic [23:0]      target_ip_ff, target_ip_in;
   logic             type_arp_ff, type_arp_in;
   logic             is_req_ff, is_req_in;
   logic             replying_ff, replying_in;
   logic             match;
   logic             at_check;

   assign at_check = (idx_ff == IDX_W'(HDR_LEN - 1));
   assign match    = type_arp_ff && is_req_ff && ({target_ip_ff, data_byte} == gw);

   always_comb begin
      idx_in       = idx_ff;
      eth_src_in   = eth_src_ff;
      fixed_in     = fixed_ff;
      sender_hw_in = sender_hw_ff;
      snd_ip_in    = snd_ip_ff;
      target_ip_in = target_ip_ff;
      type_arp_in  = type_arp_ff;
      is_req_in    = is_req_ff;
      replying_in  = replying_ff;
      if (accept) begin
         if (idx_ff inside {[6:11]}) begin
            eth_src_in = {eth_src_ff[39:0], data_byte};
         end else if (idx_ff == 6'd12) begin
            type_arp_in = (data_byte == ARP_ETHERTYPE[15:8]);
         end else if (idx_ff == 6'd13) begin
            type_arp_in = type_arp_ff && (data_byte == ARP_ETHERTYPE[7:0]);
         end else if (idx_ff inside {[14:19]}) begin
            fixed_in = {fixed_ff[39:0], data_byte};
         end else if (idx_ff == 6'd20) begin
            is_req_in = (data_byte == ARP_OP_REQ_HI);
         end else if (idx_ff == 6'd21) begin
            is_req_in = is_req_ff && (data_byte == ARP_OP_REQ_LO);
         end else if (idx_ff inside {[22:27]}) begin
            sender_hw_in = {sender_hw_ff[39:0], data_byte};
         end else if (idx_ff inside {[28:31]}) begin
            snd_ip_in = {snd_ip_ff[23:0], data_byte};
         end else if (idx_ff inside {[38:40]}) begin
            target_ip_in = {target_ip_ff[15:0], data_byte};
         end else if (at_check && match) begin
            replying_in = 1'b1;
         end
         // saturate at the header length
         if (idx_ff < IDX_W'(HDR_LEN)) begin
            idx_in = idx_ff + 1'b1;
         end
         if (frame_last) begin
            idx_in      = '0;
            type_arp_in = 1'b0;
            is_req_in   = 1'b0;
            replying_in = 1'b0;
         end
      end
   end

   always_comb begin
      load.load_reply = accept && at_check && match;
      load.load_pass  = accept && (idx_ff == IDX_W'(HDR_LEN)) && replying_ff;
      load.data       = data_byte;
      load.last       = frame_last;
      load.port       = port;
      load.hdr        = {eth_src_ff, mac, ARP_ETHERTYPE, fixed_ff, ARP_OP_REPLY,
                         mac, gw, sender_hw_ff, snd_ip_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         type_arp_ff <= 1'b0;
         is_req_ff   <= 1'b0;
         replying_ff <= 1'b0;
      end else begin
         idx_ff      <= idx_in;
         type_arp_ff <= type_arp_in;
         is_req_ff   <= is_req_in;
         replying_ff <= replying_in;
      end
   end

   always_ff @(posedge clock) begin
      eth_src_ff   <= eth_src_in;
      fixed_ff     <= fixed_in;
      sender_hw_ff <= sender_hw_in;
      snd_ip_ff    <= snd_ip_in;
      target_ip_ff <= target_ip_in;
   end

endmodule

// ===== hdl/arp_reply_shifter.sv =====
// Reply shifter: holds the reply header or one pass-through byte and
// shifts it out a byte per transaction. Depends on arp_pkg.
module arp_reply_shifter
   import arp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  load_req_type load,
   output logic         can_load,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_out_last,
   output logic         rsp_reply_port
);

   logic [HDR_BITS-1:0] sh_ff, sh_in;
   logic [IDX_W-1:0]    cnt_ff, cnt_in;
   logic                last_ff, last_in;
   logic                port_ff, port_in;
   logic                take;

   assign rsp_valid      = (cnt_ff != '0);
   assign take           = rsp_valid && !rsp_stall;
   assign can_load       = (cnt_ff == '0) || ((cnt_ff == IDX_W'(1)) && !rsp_stall);
   assign rsp_out_byte   = sh_ff[HDR_BITS-1 -: 8];
   assign rsp_out_last   = (cnt_ff == IDX_W'(1)) && last_ff;
   assign rsp_reply_port = port_ff;

   always_comb begin
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      last_in = last_ff;
      port_in = port_ff;
      if (load.load_reply) begin
         sh_in   = load.hdr;
         cnt_in  = IDX_W'(HDR_LEN);
         last_in = load.last;
         port_in = load.port;
      end else if (load.load_pass) begin
         sh_in   = {load.data, sh_ff[HDR_BITS-9:0]};
         cnt_in  = IDX_W'(1);
         last_in = load.last;
         port_in = load.port;
      end else if (take) begin
         // advance to the next reply byte
         sh_in  = {sh_ff[HDR_BITS-9:0], 8'h00};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sh_ff   <= sh_in;
      last_ff <= last_in;
      port_ff <= port_in;
   end

endmodule
